### rtl/core/rsd_pkg.sv
// Package for the running standard deviation block.
// Holds the sequencer state type and the fixed widths of the shared arithmetic.
// No dependencies.
package rsd_pkg;

  // The sum of squares is always a full 64-bit word.
  localparam int unsigned SqW = 64;

  // The square root takes one result bit per step over a 64-bit radicand.
  localparam int unsigned RootSteps = SqW / 2;

  // The step counter must hold the longest pass, which is SqW steps.
  localparam int unsigned StepCntW = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV_MEAN,
    ST_DIV_SQ,
    ST_MUL,
    ST_SUB,
    ST_SQRT,
    ST_DONE
  } rsd_state_e;

endpackage

### rtl/core/running_std_deviation.sv
// Running standard deviation of duration samples, by the sum-of-squares method.
// Top level: one sequencer driving a shared shift-and-subtract step unit.
// Depends on rsd_pkg.
//
// Usage. Each input transaction on the s_axis channel either adds one sample
// (tuser low, sample in tdata) or clears all accumulators (tuser high). Every
// input transaction yields exactly one output transaction on m_axis carrying the
// sample count, the floored mean, the floored population standard deviation and
// a flag that tells whether the sum of squares has saturated.
// Sequence. For an add, the shared step unit takes one quotient bit per cycle
// for each of the two divisions by the count, then, when the variance is
// positive, one root bit per cycle for the square root.
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Reset. rst_ni clears the count, the sum and the sum of squares, and empties the
// output register.
// Stalls. A finished result sits in the output register; while it waits the block
// may take and work on the next item, and only holds that item's result back
// until the receiver has taken the earlier one.
module running_std_deviation #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  // Input channel.
  input  logic                                               s_axis_tvalid_i,
  output logic                                               s_axis_tready_o,
  // tdata fields from bit 0: sample_ms (SAMPLE_BITS), zero padding to whole bytes.
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]           s_axis_tdata_i,
  // tuser fields from bit 0: func (1 bit, 0 = add sample, 1 = clear).
  input  logic                                               s_axis_tuser_i,
  // Output channel.
  output logic                                               m_axis_tvalid_o,
  input  logic                                               m_axis_tready_i,
  // tdata fields from bit 0: sample_count (COUNT_BITS), mean_ms (SAMPLE_BITS),
  // std_dev_ms (SAMPLE_BITS), zero padding to whole bytes.
  output logic [((COUNT_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // tuser fields from bit 0: squares_saturated (1 bit).
  output logic                                               m_axis_tuser_o
);

  localparam int unsigned SqW      = rsd_pkg::SqW;
  localparam int unsigned CntW     = rsd_pkg::StepCntW;
  localparam int unsigned SumW     = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned ProdW    = 2 * SAMPLE_BITS;
  localparam int unsigned OutW     = ((COUNT_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned RootW    = rsd_pkg::RootSteps;
  // The step unit must hold a shifted division remainder (COUNT_BITS + 1 bits)
  // and a shifted root remainder with its trial value (35 bits).
  localparam int unsigned RemW     = (COUNT_BITS + 1 > 35) ? COUNT_BITS + 1 : 35;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [RootW-1:0]      DevMax   =
    RootW'((64'd1 << SAMPLE_BITS) - 64'd1);

  rsd_pkg::rsd_state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] sample_q,  sample_d;
  logic [COUNT_BITS-1:0]  count_q,   count_d;
  logic [SumW-1:0]        sum_q,     sum_d;
  logic [SqW-1:0]         ssq_q,     ssq_d;
  logic [ProdW-1:0]       prod_q,    prod_d;
  logic [SqW-1:0]         x_q,       x_d;
  logic [RemW-1:0]        rem_q,     rem_d;
  logic [SqW-1:0]         acc_q,     acc_d;
  logic [CntW-1:0]        cnt_q,     cnt_d;
  logic [SAMPLE_BITS-1:0] mean_q,    mean_d;
  logic [SAMPLE_BITS-1:0] dev_q,     dev_d;
  logic                   m_valid_q;
  logic [OutW-1:0]        m_data_q;
  logic                   m_user_q;

  logic                   in_fire;
  logic                   out_free;
  logic                   last_step;

  // Shared step unit: one trial subtraction per cycle. In division mode the
  // next dividend bit joins the remainder and the count is tried; in root mode
  // the next two radicand bits join and the trial value is four times the
  // partial root plus one.
  logic                   root_mode;
  logic [RemW-1:0]        step_a;
  logic [RemW-1:0]        step_b;
  logic [RemW:0]          step_diff;
  logic                   step_ge;
  logic [RemW-1:0]        step_rem;
  logic [SqW-1:0]         step_acc;
  logic [SqW-1:0]         step_x;

  // Saturating accumulation of the squares.
  logic [SqW:0]           ssq_sum;
  logic [SAMPLE_BITS-1:0] mul_a;
  logic [RootW-1:0]       root;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign last_step = (cnt_q == CntW'(1));

  assign root_mode = (state_q == rsd_pkg::ST_SQRT);
  assign step_a    = root_mode ? {rem_q[RemW-3:0], x_q[SqW-1 -: 2]}
                               : {rem_q[RemW-2:0], x_q[SqW-1]};
  assign step_b    = root_mode ? {acc_q[RemW-3:0], 2'b01}
                               : RemW'(count_q);
  assign step_diff = {1'b0, step_a} - {1'b0, step_b};
  assign step_ge   = !step_diff[RemW];
  assign step_rem  = step_ge ? step_diff[RemW-1:0] : step_a;
  assign step_acc  = {acc_q[SqW-2:0], step_ge};
  assign step_x    = root_mode ? {x_q[SqW-3:0], 2'b00} : {x_q[SqW-2:0], 1'b0};

  assign ssq_sum   = {1'b0, ssq_q} + {1'b0, SqW'(prod_q)};
  assign mul_a     = (state_q == rsd_pkg::ST_SQUARE) ? sample_q : mean_q;
  assign root      = step_acc[RootW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rsd_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = s_axis_tuser_i ? rsd_pkg::ST_DONE : rsd_pkg::ST_SQUARE;
        end
      end
      rsd_pkg::ST_SQUARE:   state_d = rsd_pkg::ST_ACCUM;
      // After an add the count is never zero, so both divisions are safe.
      rsd_pkg::ST_ACCUM:    state_d = rsd_pkg::ST_DIV_MEAN;
      rsd_pkg::ST_DIV_MEAN: begin
        if (last_step) begin
          state_d = rsd_pkg::ST_DIV_SQ;
        end
      end
      rsd_pkg::ST_DIV_SQ: begin
        if (last_step) begin
          state_d = rsd_pkg::ST_MUL;
        end
      end
      rsd_pkg::ST_MUL:      state_d = rsd_pkg::ST_SUB;
      rsd_pkg::ST_SUB: begin
        state_d = (x_q > SqW'(prod_q)) ? rsd_pkg::ST_SQRT : rsd_pkg::ST_DONE;
      end
      rsd_pkg::ST_SQRT: begin
        if (last_step) begin
          state_d = rsd_pkg::ST_DONE;
        end
      end
      rsd_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = rsd_pkg::ST_IDLE;
        end
      end
      default:              state_d = rsd_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_axis_tready_o = (state_q == rsd_pkg::ST_IDLE);
    m_axis_tvalid_o = m_valid_q;
    m_axis_tdata_o  = m_data_q;
    m_axis_tuser_o  = m_user_q;
  end

  // Datapath.
  always_comb begin
    sample_d = sample_q;
    count_d  = count_q;
    sum_d    = sum_q;
    ssq_d    = ssq_q;
    prod_d   = prod_q;
    x_d      = x_q;
    rem_d    = rem_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    mean_d   = mean_q;
    dev_d    = dev_q;
    case (state_q)
      rsd_pkg::ST_IDLE: begin
        if (in_fire) begin
          sample_d = s_axis_tdata_i[SAMPLE_BITS-1:0];
          if (s_axis_tuser_i) begin
            count_d = '0;
            sum_d   = '0;
            ssq_d   = '0;
            mean_d  = '0;
            dev_d   = '0;
          end
        end
      end
      rsd_pkg::ST_SQUARE: begin
        prod_d = ProdW'(mul_a) * ProdW'(mul_a);
      end
      rsd_pkg::ST_ACCUM: begin
        // A full count ignores the sample altogether so the mean stays sound.
        if (count_q != CountMax) begin
          count_d = count_q + COUNT_BITS'(1);
          sum_d   = sum_q + SumW'(sample_q);
          if (ssq_sum[SqW] || (&ssq_sum[SqW-1:0])) begin
            ssq_d = {SqW{1'b1}};
          end else begin
            ssq_d = ssq_sum[SqW-1:0];
          end
        end
        x_d   = {sum_d, {(SqW - SumW){1'b0}}};
        rem_d = '0;
        acc_d = '0;
        cnt_d = CntW'(SumW);
      end
      rsd_pkg::ST_DIV_MEAN: begin
        rem_d = step_rem;
        acc_d = step_acc;
        x_d   = step_x;
        cnt_d = cnt_q - CntW'(1);
        if (last_step) begin
          // The mean never exceeds the largest sample.
          mean_d = step_acc[SAMPLE_BITS-1:0];
          x_d    = ssq_q;
          rem_d  = '0;
          acc_d  = '0;
          cnt_d  = CntW'(SqW);
        end
      end
      rsd_pkg::ST_DIV_SQ: begin
        rem_d = step_rem;
        acc_d = step_acc;
        x_d   = step_x;
        cnt_d = cnt_q - CntW'(1);
        if (last_step) begin
          // The mean square waits in the shift register for the subtraction.
          x_d = step_acc;
        end
      end
      rsd_pkg::ST_MUL: begin
        prod_d = ProdW'(mul_a) * ProdW'(mul_a);
      end
      rsd_pkg::ST_SUB: begin
        if (x_q > SqW'(prod_q)) begin
          x_d   = x_q - SqW'(prod_q);
          rem_d = '0;
          acc_d = '0;
          cnt_d = CntW'(RootW);
        end else begin
          dev_d = '0;
        end
      end
      rsd_pkg::ST_SQRT: begin
        rem_d = step_rem;
        acc_d = step_acc;
        x_d   = step_x;
        cnt_d = cnt_q - CntW'(1);
        if (last_step) begin
          dev_d = (root > DevMax) ? DevMax[SAMPLE_BITS-1:0] : root[SAMPLE_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rsd_pkg::ST_IDLE;
      count_q   <= '0;
      sum_q     <= '0;
      ssq_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      ssq_q   <= ssq_d;
      if ((state_q == rsd_pkg::ST_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    prod_q   <= prod_d;
    x_q      <= x_d;
    rem_q    <= rem_d;
    acc_q    <= acc_d;
    cnt_q    <= cnt_d;
    mean_q   <= mean_d;
    dev_q    <= dev_d;
    if ((state_q == rsd_pkg::ST_DONE) && out_free) begin
      m_data_q <= OutW'({dev_q, mean_q, count_q});
      m_user_q <= &ssq_q;
    end
  end

endmodule
